// ===== rtl/gcl_pkg.sv =====
// Shared types, constants and the microcode program of the GCD/LCM unit.
package gcl_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int W             = OPERAND_WIDTH;
    localparam int KW            = (W > 1) ? $clog2(W) : 1;
    localparam int STEP_W        = 4;

    typedef struct packed {
        logic [31:0] value_a;
        logic [31:0] value_b;
    } gcl_in_t;

    typedef struct packed {
        logic [31:0] gcd_value;
        logic [63:0] lcm_value;
    } gcl_out_t;

    // Datapath operations, one per control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_EUC_INIT,
        OP_ALIGN,
        OP_SUB,
        OP_SWAP,
        OP_LCM_INIT,
        OP_MUL_INIT,
        OP_MUL_STEP,
        OP_ZERO,
        OP_EMIT
    } gcl_op_t;

    // Jump conditions; when false the step counter advances by one.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_Y_ZERO,
        C_AB_ZERO,
        C_ALIGN_MORE,
        C_K_NONZERO,
        C_MP_MORE
    } gcl_cond_t;

    typedef struct packed {
        gcl_op_t             op;
        gcl_cond_t           cond;
        logic [STEP_W-1:0]   target;
    } gcl_ctrl_t;

    typedef struct packed {
        logic y_zero;
        logic ab_zero;
        logic align_more;
        logic k_nonzero;
        logic mp_more;
    } gcl_status_t;

    // Program labels
    localparam logic [STEP_W-1:0] S_IDLE      = 4'd0;
    localparam logic [STEP_W-1:0] S_EUC_TEST  = 4'd1;
    localparam logic [STEP_W-1:0] S_EUC_INIT  = 4'd2;
    localparam logic [STEP_W-1:0] S_EUC_ALIGN = 4'd3;
    localparam logic [STEP_W-1:0] S_EUC_SUB   = 4'd4;
    localparam logic [STEP_W-1:0] S_EUC_SWAP  = 4'd5;
    localparam logic [STEP_W-1:0] S_LCM_TEST  = 4'd6;
    localparam logic [STEP_W-1:0] S_LCM_INIT  = 4'd7;
    localparam logic [STEP_W-1:0] S_LCM_ALIGN = 4'd8;
    localparam logic [STEP_W-1:0] S_LCM_SUB   = 4'd9;
    localparam logic [STEP_W-1:0] S_MUL_INIT  = 4'd10;
    localparam logic [STEP_W-1:0] S_MUL_STEP  = 4'd11;
    localparam logic [STEP_W-1:0] S_EMIT      = 4'd12;
    localparam logic [STEP_W-1:0] S_ZERO      = 4'd13;

    function automatic gcl_ctrl_t gcl_rom(input logic [STEP_W-1:0] step);
        gcl_ctrl_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
        unique case (step)
            S_IDLE:      w = '{op: OP_LOAD,     cond: C_NO_START,   target: S_IDLE};
            S_EUC_TEST:  w = '{op: OP_NOP,      cond: C_Y_ZERO,     target: S_LCM_TEST};
            S_EUC_INIT:  w = '{op: OP_EUC_INIT, cond: C_NEVER,      target: S_IDLE};
            S_EUC_ALIGN: w = '{op: OP_ALIGN,    cond: C_ALIGN_MORE, target: S_EUC_ALIGN};
            S_EUC_SUB:   w = '{op: OP_SUB,      cond: C_K_NONZERO,  target: S_EUC_SUB};
            S_EUC_SWAP:  w = '{op: OP_SWAP,     cond: C_ALWAYS,     target: S_EUC_TEST};
            S_LCM_TEST:  w = '{op: OP_NOP,      cond: C_AB_ZERO,    target: S_ZERO};
            S_LCM_INIT:  w = '{op: OP_LCM_INIT, cond: C_NEVER,      target: S_IDLE};
            S_LCM_ALIGN: w = '{op: OP_ALIGN,    cond: C_ALIGN_MORE, target: S_LCM_ALIGN};
            S_LCM_SUB:   w = '{op: OP_SUB,      cond: C_K_NONZERO,  target: S_LCM_SUB};
            S_MUL_INIT:  w = '{op: OP_MUL_INIT, cond: C_NEVER,      target: S_IDLE};
            S_MUL_STEP:  w = '{op: OP_MUL_STEP, cond: C_MP_MORE,    target: S_MUL_STEP};
            S_EMIT:      w = '{op: OP_EMIT,     cond: C_ALWAYS,     target: S_IDLE};
            S_ZERO:      w = '{op: OP_ZERO,     cond: C_ALWAYS,     target: S_EMIT};
            default:     w = '{op: OP_NOP,      cond: C_ALWAYS,     target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/gcl_sequencer.sv =====
// Step counter, microcode table lookup and jump logic.
module gcl_sequencer
    import gcl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  gcl_status_t status,
    output gcl_op_t     op,
    output logic        busy
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    gcl_ctrl_t         word;
    logic              take_jump;

    always_comb
    begin
        word = gcl_rom(step_reg);
    end

    always_comb
    begin
        unique case (word.cond)
            C_NEVER:      take_jump = 1'b0;
            C_ALWAYS:     take_jump = 1'b1;
            C_NO_START:   take_jump = !start;
            C_Y_ZERO:     take_jump = status.y_zero;
            C_AB_ZERO:    take_jump = status.ab_zero;
            C_ALIGN_MORE: take_jump = status.align_more;
            C_K_NONZERO:  take_jump = status.k_nonzero;
            C_MP_MORE:    take_jump = status.mp_more;
            default:      take_jump = 1'b1;
        endcase
    end

    always_comb
    begin
        step_next = take_jump ? word.target : step_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign op   = word.op;
    assign busy = (step_reg != S_IDLE);

endmodule

// ===== rtl/gcl_datapath.sv =====
// Operand registers, shift-subtract divider, shift-add multiplier and result register.
module gcl_datapath
    import gcl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  gcl_op_t     op,
    input  gcl_in_t     operands,
    output gcl_status_t status,
    output gcl_out_t    result,
    output logic        done
);

    logic [W-1:0]   x_reg, x_next;
    logic [W-1:0]   y_reg, y_next;
    logic [W-1:0]   a_reg, a_next;
    logic [W-1:0]   b_reg, b_next;
    logic [W-1:0]   r_reg, r_next;
    logic [W-1:0]   d_reg, d_next;
    logic [W-1:0]   q_reg, q_next;
    logic [KW-1:0]  k_reg, k_next;
    logic [2*W-1:0] mc_reg, mc_next;
    logic [W-1:0]   mp_reg, mp_next;
    logic [2*W-1:0] p_reg, p_next;
    gcl_out_t       result_reg, result_next;
    logic           done_reg, done_next;

    logic           align_more;
    logic           r_ge_d;

    // Divisor may still double without passing the running remainder.
    assign align_more = !d_reg[W-1] && ({d_reg, 1'b0} <= {1'b0, r_reg});
    assign r_ge_d     = (r_reg >= d_reg);

    assign status.y_zero     = (y_reg == '0);
    assign status.ab_zero    = (a_reg == '0) || (b_reg == '0);
    assign status.align_more = align_more;
    assign status.k_nonzero  = (k_reg != '0);
    assign status.mp_more    = (mp_reg[W-1:1] != '0);

    always_comb
    begin
        x_next      = x_reg;
        y_next      = y_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        r_next      = r_reg;
        d_next      = d_reg;
        q_next      = q_reg;
        k_next      = k_reg;
        mc_next     = mc_reg;
        mp_next     = mp_reg;
        p_next      = p_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        unique case (op)
            OP_NOP:
            begin
            end
            OP_LOAD:
            begin
                x_next = operands.value_a[W-1:0];
                y_next = operands.value_b[W-1:0];
                a_next = operands.value_a[W-1:0];
                b_next = operands.value_b[W-1:0];
            end
            OP_EUC_INIT:
            begin
                r_next = x_reg;
                d_next = y_reg;
                q_next = '0;
                k_next = '0;
            end
            OP_LCM_INIT:
            begin
                r_next = a_reg;
                d_next = x_reg;
                q_next = '0;
                k_next = '0;
            end
            OP_ALIGN:
            begin
                if (align_more)
                begin
                    d_next = {d_reg[W-2:0], 1'b0};
                    k_next = k_reg + 1'b1;
                end
            end
            OP_SUB:
            begin
                if (r_ge_d)
                begin
                    r_next = r_reg - d_reg;
                end
                q_next = {q_reg[W-2:0], r_ge_d};
                if (k_reg != '0)
                begin
                    d_next = {1'b0, d_reg[W-1:1]};
                    k_next = k_reg - 1'b1;
                end
            end
            OP_SWAP:
            begin
                x_next = y_reg;
                y_next = r_reg;
            end
            OP_MUL_INIT:
            begin
                mc_next = (2*W)'(q_reg);
                mp_next = b_reg;
                p_next  = '0;
            end
            OP_MUL_STEP:
            begin
                if (mp_reg[0])
                begin
                    p_next = p_reg + mc_reg;
                end
                mc_next = {mc_reg[2*W-2:0], 1'b0};
                mp_next = {1'b0, mp_reg[W-1:1]};
            end
            OP_ZERO:
            begin
                p_next = '0;
            end
            OP_EMIT:
            begin
                result_next.gcd_value = 32'(x_reg);
                result_next.lcm_value = 64'(p_reg);
                done_next             = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        r_reg      <= r_next;
        d_reg      <= d_next;
        q_reg      <= q_next;
        k_reg      <= k_next;
        mc_reg     <= mc_next;
        mp_reg     <= mp_next;
        p_reg      <= p_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

// ===== rtl/gcd_lcm_unit.sv =====
// Each item runs Euclid steps by shift-subtract division, then divides a by the gcd and
// forms the lcm as a shift-add product of that quotient and b; a zero operand gives lcm 0.
// One item at a time: busy is high from acceptance until the result strobe.
// The result shows for one cycle on done; the receiver cannot stall it.
// rst_n clears the step counter and the strobe; the block then waits for start.
module gcd_lcm_unit
    import gcl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  gcl_in_t  operands,
    output logic     busy,
    output logic     done,
    output gcl_out_t result
);

    gcl_op_t     op;
    gcl_status_t status;

    gcl_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .op     (op),
        .busy   (busy)
    );

    gcl_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .operands (operands),
        .status   (status),
        .result   (result),
        .done     (done)
    );

endmodule

// ===== rtl/gcl_checker.sv =====
// Port-level checks for the GCD/LCM unit, bound to the top level.
module gcl_checker
    import gcl_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input gcl_out_t result
);

    logic accept;
    assign accept = start && !busy;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after item accepted");

    a_no_done_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !done)
        else $error("result strobe right after acceptance");

    a_idle_at_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_zero_gcd_zero_lcm: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.gcd_value == '0)) |-> (result.lcm_value == '0))
        else $error("nonzero lcm with zero gcd");

    a_lcm_multiple: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.lcm_value != '0)) |-> (result.gcd_value != '0))
        else $error("nonzero lcm without a divisor");

endmodule

bind gcd_lcm_unit gcl_checker u_gcl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .result   (result)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for the GCD/LCM unit: corner operands, random pairs and gap patterns.
module tb_top
    import gcl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 600;

    typedef struct {
        gcl_in_t  item;
        gcl_out_t want;
    } pending_t;

    logic     clk;
    logic     rst_n    = 1'b0;
    logic     start    = 1'b0;
    gcl_in_t  operands = '0;
    logic     busy;
    logic     done;
    gcl_out_t result;

    pending_t pending_results[$];
    int       error_count  = 0;
    int       quiet_cycles = 0;

    gcd_lcm_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .operands (operands),
        .busy     (busy),
        .done     (done),
        .result   (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Euclid by remainders, then (a/g)*b widened to 64 bits.
    function automatic gcl_out_t gcd_lcm_expect(input gcl_in_t item);
        logic [63:0] mask;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] r;
        gcl_out_t    expected;
        mask = (64'd1 << OPERAND_WIDTH) - 64'd1;
        a = item.value_a & mask[31:0];
        b = item.value_b & mask[31:0];
        x = a;
        y = b;
        while (y != 32'd0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        expected.gcd_value = x;
        expected.lcm_value = 64'd0;
        if (a != 32'd0 && b != 32'd0)
            expected.lcm_value = {32'd0, a / x} * {32'd0, b};
        return expected;
    endfunction

    // Consecutive Fibonacci numbers give the longest remainder chains.
    function automatic gcl_in_t fibonacci_pair(input int n);
        logic [63:0] f0;
        logic [63:0] f1;
        logic [63:0] f2;
        gcl_in_t     pair;
        f0 = 64'd0;
        f1 = 64'd1;
        for (int i = 0; i < n; i++)
        begin
            f2 = f0 + f1;
            f0 = f1;
            f1 = f2;
        end
        pair.value_a = f1[31:0];
        pair.value_b = f0[31:0];
        return pair;
    endfunction

    function automatic gcl_in_t random_operands();
        gcl_in_t     pair;
        logic [31:0] k;
        int          kind;
        kind = $urandom_range(0, 9);
        pair.value_a = $urandom();
        pair.value_b = $urandom();
        case (kind)
            4:
            begin
                pair.value_a = $urandom_range(0, 255);
                pair.value_b = $urandom_range(0, 255);
            end
            5:
            begin
                k = $urandom_range(1, 65535);
                pair.value_a = k * $urandom_range(0, 65535);
                pair.value_b = k * $urandom_range(0, 65535);
            end
            6:
            begin
                if ($urandom_range(0, 2) != 0)
                    pair.value_a = 32'd0;
                if ($urandom_range(0, 2) != 0)
                    pair.value_b = 32'd0;
            end
            7:
            begin
                k = $urandom_range(1, 1000);
                pair.value_b = $urandom_range(1, 4000000);
                pair.value_a = pair.value_b * k;
                if ($urandom_range(0, 1) == 1)
                    pair = '{value_a: pair.value_b, value_b: pair.value_a};
            end
            8:
            begin
                pair.value_a = 32'd1 << $urandom_range(0, 31);
                pair.value_b = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                                             : 32'd1 << $urandom_range(0, 31);
            end
            9:
            begin
                pair = fibonacci_pair($urandom_range(1, 46));
                if ($urandom_range(0, 1) == 1)
                    pair = '{value_a: pair.value_b, value_b: pair.value_a};
            end
            default:
            begin
            end
        endcase
        return pair;
    endfunction

    // Hold start high until the block takes the item; leave it high for a follow-on.
    task automatic send_item(input gcl_in_t item);
        pending_t entry;
        start    <= 1'b1;
        operands <= item;
        do
            @(posedge clk);
        while (busy);
        entry.item = item;
        entry.want = gcd_lcm_expect(item);
        pending_results.push_back(entry);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int count, input int gap_pct);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(1, 100) <= gap_pct)
            begin
                if ($urandom_range(0, 3) == 0)
                    idle_cycles($urandom_range(20, 300));
                else
                    idle_cycles($urandom_range(1, 8));
            end
            send_item(random_operands());
        end
    endtask

    task automatic test_corner_operands();
        send_item('{value_a: 32'd0, value_b: 32'd0});
        send_item('{value_a: 32'd0, value_b: 32'd12345});
        send_item('{value_a: 32'hFFFF_FFFF, value_b: 32'd0});
        send_item('{value_a: 32'd0, value_b: 32'hFFFF_FFFF});
        send_item('{value_a: 32'd1, value_b: 32'd1});
        send_item('{value_a: 32'hFFFF_FFFF, value_b: 32'hFFFF_FFFF});
        send_item('{value_a: 32'hFFFF_FFFF, value_b: 32'hFFFF_FFFE});
        send_item('{value_a: 32'hFFFF_FFFE, value_b: 32'hFFFF_FFFF});
        send_item('{value_a: 32'hFFFF_FFFF, value_b: 32'd1});
        send_item('{value_a: 32'd1, value_b: 32'hFFFF_FFFF});
        send_item('{value_a: 32'h8000_0000, value_b: 32'h8000_0000});
        send_item('{value_a: 32'h8000_0000, value_b: 32'd1});
        send_item('{value_a: 32'h5555_5555, value_b: 32'hAAAA_AAAA});
        send_item('{value_a: 32'd4294967291, value_b: 32'd4294967279});
        send_item(fibonacci_pair(46));
        send_item(fibonacci_pair(45));
        send_item('{value_a: 32'd12, value_b: 32'd18});
        send_item('{value_a: 32'd7, value_b: 32'd7000007});
        send_item('{value_a: 32'd65536, value_b: 32'd65535});
        send_item('{value_a: 32'd3, value_b: 32'hFFFF_FFFF});
        wait_drained();
    endtask

    task automatic test_back_to_back();
        run_random(600, 0);
    endtask

    task automatic test_sender_gaps();
        run_random(600, 45);
    endtask

    task automatic test_light_gaps();
        run_random(500, 16);
    endtask

    // Let the unit empty out completely between short bursts.
    task automatic test_drain_pauses();
        for (int burst = 0; burst < 30; burst++)
        begin
            run_random($urandom_range(1, 10), 16);
            wait_drained();
            idle_cycles($urandom_range(1, 20));
        end
    endtask

    always @(posedge clk)
    begin : check_results
        pending_t head;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_error($sformatf("unexpected result gcd=%0d lcm=%0d",
                                       result.gcd_value, result.lcm_value));
            else
            begin
                head = pending_results.pop_front();
                if (result.gcd_value !== head.want.gcd_value)
                    report_error($sformatf("a=%0d b=%0d gcd got %0d want %0d",
                                           head.item.value_a, head.item.value_b,
                                           result.gcd_value, head.want.gcd_value));
                if (result.lcm_value !== head.want.lcm_value)
                    report_error($sformatf("a=%0d b=%0d lcm got %0d want %0d",
                                           head.item.value_a, head.item.value_b,
                                           result.lcm_value, head.want.lcm_value));
            end
        end
    end

    // Abort when neither an item nor a result moves for too long.
    always @(posedge clk)
    begin
        if (rst_n && ((start && !busy) || done))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_corner_operands();
        test_back_to_back();
        test_sender_gaps();
        test_light_gaps();
        test_drain_pauses();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_results.size()));

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
